@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk_i, rst_ni, cond) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_i, rst_ni, cond)

`define ASSERT_IMPLY(lbl, clk_i, rst_ni, ante, cons)

`define ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)

`endif

`endif

@@ rtl/sms_pkg.sv @@
// ---------------------------------------------------------------------------
// Shuffled mode sequencer package
// Fixed widths, reset constants, sequencer states and the xorshift step.
// ---------------------------------------------------------------------------
package sms_pkg;

    localparam int CNT_W  = 16;
    localparam int RNG_W  = 16;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 4;

    localparam logic [RNG_W-1:0] SEED_VALUE   = 16'hBEEF;
    localparam logic [CNT_W-1:0] FRAMES_RESET = 16'd188;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_RAND,
        ST_MOD,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_RD_OUT,
        ST_EMIT
    } sms_state_t;

    function automatic logic [RNG_W-1:0] xorshift_step(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] a;
        logic [RNG_W-1:0] b;
        a = x ^ (x << 7);
        b = a ^ (a >> 9);
        return b ^ (b << 8);
    endfunction

endpackage

@@ rtl/sms_mod_unit.sv @@
// ---------------------------------------------------------------------------
// Byte modulo unit
// Restoring remainder of an 8-bit value by a small divisor, one bit a cycle.
// ---------------------------------------------------------------------------
module sms_mod_unit #(
    parameter int DIV_W = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [sms_pkg::BYTE_W-1:0] dividend,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     done,
    output logic [DIV_W-1:0]         remainder
);
    import sms_pkg::*;

    localparam int STEP_W = $clog2(BYTE_W);

    logic               busy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [BYTE_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   rem_next;
    logic [DIV_W:0]     shifted;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[BYTE_W-1]};
        if (shifted >= {1'b0, div_reg})
        begin
            shifted = shifted - {1'b0, div_reg};
        end
        rem_next = shifted[DIV_W-1:0];
    end

    assign done      = busy_reg && (step_reg == STEP_W'(BYTE_W - 1));
    assign remainder = rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

endmodule

@@ rtl/shuffled_mode_sequencer.sv @@
// ---------------------------------------------------------------------------
// Shuffled mode sequencer
// Counts frame ticks and emits the next mode of a Fisher-Yates shuffled
// order at each switch, reshuffling with a 16-bit xorshift generator.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[0] frame_tick
//  m_*       out  m_tvalid/m_tready  m_tdata[3:0] mode_number, m_tuser[0] new_round
//  cfg_*     in   cfg_wen            cfg_wdata[15:0] frames_per_switch
//
//  A tick that does not switch stays in ST_IDLE; a switch runs ST_RD_OUT and
//  ST_EMIT, waiting on m_tready. Reshuffle: ST_FILL, then per swap ST_RAND, the
//  bit-serial modulo unit in ST_MOD, then the swap through order_mem.
//  After reset the same shuffle runs once before s_tready rises.
//  A finished item waits in the output register while the next tick is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shuffled_mode_sequencer #(
    parameter int MODE_COUNT = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] frame_tick
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [3:0] mode_number
    output logic [0:0]                 m_tuser,   // [0] new_round
    input  logic                       cfg_wen,
    input  logic [sms_pkg::CNT_W-1:0]  cfg_wdata
);
    import sms_pkg::*;

    localparam int IDX_W = $clog2(MODE_COUNT);
    localparam int POS_W = $clog2(MODE_COUNT + 1);

    sms_state_t        state_reg, state_next;
    logic [RNG_W-1:0]  rng_reg, rng_next;
    logic [CNT_W-1:0]  frames_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  count_inc;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  swap_reg, swap_next;
    logic [IDX_W-1:0]  hold_reg, hold_next;
    logic              fresh_reg, fresh_next;
    logic              boot_reg, boot_next;
    logic              out_valid_reg, out_valid_next;
    logic [MODE_W-1:0] out_mode_reg, out_mode_next;
    logic              out_round_reg, out_round_next;
    logic              load_out;

    logic [IDX_W-1:0]  order_mem [MODE_COUNT];
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  wr_data;
    logic [MODE_W+IDX_W-1:0] entry_ext;

    logic              mod_start;
    logic              mod_done;
    logic [POS_W-1:0]  mod_rem;
    logic [RNG_W-1:0]  rng_step;

    sms_mod_unit #(
        .DIV_W(POS_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (rng_step[BYTE_W-1:0]),
        .divisor   (POS_W'(idx_reg) + POS_W'(1)),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign rng_step  = xorshift_step(rng_reg);
    assign count_inc = count_reg + CNT_W'(1);
    assign entry_ext = {{MODE_W{1'b0}}, rd_data_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - MODE_W){1'b0}}, out_mode_reg};
    assign m_tuser  = out_round_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            order_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= order_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        rng_next       = rng_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        swap_next      = swap_reg;
        hold_next      = hold_reg;
        fresh_next     = fresh_reg;
        boot_next      = boot_reg;
        rd_addr        = pos_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = idx_reg;
        mod_start      = 1'b0;
        load_out       = 1'b0;
        out_mode_next  = out_mode_reg;
        out_round_next = out_round_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tdata[0])
                begin
                    if (count_inc >= frames_reg)
                    begin
                        count_next = '0;
                        if (pos_reg == POS_W'(MODE_COUNT))
                        begin
                            fresh_next = 1'b1;
                            idx_next   = '0;
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            fresh_next = 1'b0;
                            state_next = ST_RD_OUT;
                        end
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            ST_FILL:
            begin
                wr_en = 1'b1;
                if (idx_reg == IDX_W'(MODE_COUNT - 1))
                begin
                    state_next = ST_RAND;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_RAND:
            begin
                rng_next   = rng_step;
                mod_start  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    swap_next  = mod_rem[IDX_W-1:0];
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:
            begin
                rd_addr    = idx_reg;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                rd_addr    = swap_reg;
                hold_next  = rd_data_reg;
                state_next = ST_WR_I;
            end
            ST_WR_I:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data_reg;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                wr_en    = 1'b1;
                wr_addr  = swap_reg;
                wr_data  = hold_reg;
                pos_next = '0;
                if (idx_reg == IDX_W'(1))
                begin
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD_OUT;
                    end
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_RAND;
                end
            end
            ST_RD_OUT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    out_mode_next  = entry_ext[MODE_W-1:0];
                    out_round_next = fresh_reg;
                    pos_next       = pos_reg + POS_W'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            rng_reg       <= SEED_VALUE;
            frames_reg    <= FRAMES_RESET;
            count_reg     <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            fresh_reg     <= 1'b0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rng_reg       <= rng_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            fresh_reg     <= fresh_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                frames_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        swap_reg      <= swap_next;
        hold_reg      <= hold_next;
        out_mode_reg  <= out_mode_next;
        out_round_reg <= out_round_next;
    end

    `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_reg <= POS_W'(MODE_COUNT))
    `ASSERT_IMPLY(a_swap_in_range, clk, rst_n, state_reg == ST_RD_I, swap_reg <= idx_reg)
    `ASSERT_NEXT(a_fresh_first, clk, rst_n, load_out && fresh_reg, pos_reg == POS_W'(1))
    `ASSERT_IMPLY(a_no_switch_at_end, clk, rst_n, state_reg == ST_RD_OUT,
                  pos_reg != POS_W'(MODE_COUNT))

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Shuffled mode sequencer testbench
// Streams frame-tick items into the sequencer under several frame limits and
// handshake idling patterns. A local shuffle-order predictor forecasts every
// mode switch, and the monitor checks mode and round flag of each result item.
// ---------------------------------------------------------------------------
module tb;

    localparam int MODES       = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE      = 32;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_kind_t;

    typedef struct packed {
        logic [3:0] mode;
        logic       fresh;
    } mode_switch_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [7:0]                m_tdata;
    logic [0:0]                m_tuser;
    logic                      cfg_wen   = 1'b0;
    logic [sms_pkg::CNT_W-1:0] cfg_wdata = '0;

    logic [15:0]               prng_word;
    logic [7:0]                mode_order [MODES];
    int                        order_idx;
    logic [15:0]               tick_count;
    logic [15:0]               switch_limit;

    bit                        tick_queue [$];
    mode_switch_t              pending_switches [$];
    idle_kind_t                idle_mode = IDLE_NONE;
    bit                        s_taken   = 1'b0;
    int                        errors    = 0;
    int                        quiet_cycles = 0;

    shuffled_mode_sequencer #(
        .MODE_COUNT(MODES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rng_byte();
        logic [15:0] x;
        x = prng_word;
        x = x ^ (x << 7);
        x = x ^ (x >> 9);
        x = x ^ (x << 8);
        prng_word = x;
        return x[7:0];
    endfunction

    function automatic void reshuffle();
        int         j;
        logic [7:0] held;
        for (int i = 0; i < MODES; i++)
        begin
            mode_order[i] = 8'(i);
        end
        for (int i = MODES - 1; i > 0; i--)
        begin
            j = int'(rng_byte()) % (i + 1);
            held = mode_order[i];
            mode_order[i] = mode_order[j];
            mode_order[j] = held;
        end
        order_idx = 0;
    endfunction

    function automatic void reset_model();
        prng_word    = sms_pkg::SEED_VALUE;
        switch_limit = sms_pkg::FRAMES_RESET;
        tick_count   = '0;
        reshuffle();
    endfunction

    function automatic bit take_tick(input bit tick, output mode_switch_t sw);
        sw = '0;
        if (!tick)
            return 1'b0;
        tick_count = tick_count + 16'd1;
        if (tick_count < switch_limit)
            return 1'b0;
        tick_count = '0;
        if (order_idx >= MODES)
        begin
            reshuffle();
            sw.fresh = 1'b1;
        end
        sw.mode = mode_order[order_idx][3:0];
        order_idx++;
        return 1'b1;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // driver
    always @(negedge clk)
    begin
        bit next_tick;
        int send_pct;
        int recv_pct;
        send_pct = (idle_mode == IDLE_SEND) ? 69 : (idle_mode == IDLE_BOTH) ? 25 : 0;
        recv_pct = (idle_mode == IDLE_RECV) ? 69 : (idle_mode == IDLE_BOTH) ? 25 : 0;
        if (rst_n)
        begin
            if (!s_tvalid || s_taken)
            begin
                s_taken = 1'b0;
                if (tick_queue.size() > 0 && !roll(send_pct))
                begin
                    next_tick = tick_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= 8'(next_tick);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !roll(recv_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        mode_switch_t sw;
        mode_switch_t want;
        bit           busy;
        if (rst_n)
        begin
            busy = cfg_wen;
            if (s_tvalid && s_tready)
            begin
                busy = 1'b1;
                s_taken = 1'b1;
                if (take_tick(s_tdata[0], sw))
                    pending_switches.push_back(sw);
            end
            if (m_tvalid && m_tready)
            begin
                busy = 1'b1;
                if (pending_switches.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual mode %0d new_round %0d",
                             $time, m_tdata[3:0], m_tuser[0]);
                    errors++;
                end
                else
                begin
                    want = pending_switches.pop_front();
                    if (m_tdata[3:0] != want.mode)
                    begin
                        $display("%0t: mode_number expected %0d actual %0d",
                                 $time, want.mode, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tuser[0] != want.fresh)
                    begin
                        $display("%0t: new_round expected %0d actual %0d",
                                 $time, want.fresh, m_tuser[0]);
                        errors++;
                    end
                end
            end
            if (busy)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("shuffled_mode_sequencer: mismatch");
                $finish;
            end
        end
    end

    task automatic drain();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || s_tvalid || pending_switches.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apply_limit(input logic [15:0] value);
        drain();
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        switch_limit = value;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic queue_ticks(input int count);
        int ones;
        ones = 0;
        while (ones < count)
        begin
            if (roll(20))
            begin
                tick_queue.push_back(1'b0);
            end
            else
            begin
                tick_queue.push_back(1'b1);
                ones++;
            end
        end
    endtask

    initial
    begin
        int          pick;
        logic [15:0] lim;
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hold the reset limit, mix in ignored items
        tick_queue = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        drain();
        // zero limit: every tick switches
        apply_limit(16'd0);
        tick_queue = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        drain();
        apply_limit(16'hFFFF);
        tick_queue = '{1'b1, 1'b1, 1'b0, 1'b1};
        drain();
        apply_limit(16'd1);
        tick_queue = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        drain();

        for (int p = 0; p < 24; p++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                lim = 16'd0;
            else if (pick == 1)
                lim = 16'hFFFF;
            else if (pick <= 3)
                lim = 16'($urandom_range(5, 40));
            else
                lim = 16'($urandom_range(1, 4));
            apply_limit(lim);
            idle_mode = idle_kind_t'(p % 4);
            queue_ticks(21);
            drain();
        end

        if (errors == 0)
            $display("shuffled_mode_sequencer: match");
        else
            $display("shuffled_mode_sequencer: mismatch");
        $finish;
    end

endmodule
